@@ sv/pmct_pkg.sv @@
`timescale 1ns / 1ps

package pmct_pkg;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 12;
  localparam int CUR_W    = 9;
  localparam int APP_W    = 3;
  localparam int ROW_W    = 8;
  localparam int CFG_W    = 12;
  localparam int CFG_AW   = 2;
  localparam int IN_DW    = 8;
  localparam int OUT_DW   = 24;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_X_LIMIT   = 2'd0;
  localparam logic [CFG_AW-1:0] REG_Y_LIMIT   = 2'd1;
  localparam logic [CFG_AW-1:0] REG_DOCK_ROW  = 2'd2;
  localparam logic [CFG_AW-1:0] REG_FOCUS_APP = 2'd3;

  localparam logic [POS_W-1:0] X_LIMIT_RST   = 12'd2520;
  localparam logic [POS_W-1:0] Y_LIMIT_RST   = 12'd1880;
  localparam logic [ROW_W-1:0] DOCK_ROW_RST  = 8'd220;
  localparam logic [APP_W-1:0] FOCUS_APP_RST = 3'd0;

  // first byte flag bits
  localparam int Y_OVF_BIT = 7;
  localparam int X_OVF_BIT = 6;
  localparam int LEFT_BIT  = 0;

  // byte slot codes
  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  typedef struct packed {
    logic [POS_W-1:0] x_limit;
    logic [POS_W-1:0] y_limit;
    logic [ROW_W-1:0] dock_row;
    logic [APP_W-1:0] focus_app;
  } cfg_t;

  typedef struct packed {
    logic              last_slot;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;
  } frame_t;

  typedef struct packed {
    logic [CUR_W-1:0] cursor_x;
    logic [CUR_W-1:0] cursor_y;
    logic             click;
    logic [APP_W-1:0] target_app;
  } result_t;

endpackage

@@ sv/pmct_framer.sv @@
`timescale 1ns / 1ps

module pmct_framer (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic [pmct_pkg::BYTE_W-1:0] rx_byte,
  output pmct_pkg::frame_t       frame
);
  import pmct_pkg::*;

  logic [1:0]        byte_index;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index  <= SLOT_FIRST;
      first_byte  <= '0;
      second_byte <= '0;
    end else if (take) begin
      case (byte_index)
        SLOT_SECOND: begin
          second_byte <= rx_byte;
          byte_index  <= SLOT_THIRD;
        end
        SLOT_THIRD: begin
          byte_index <= SLOT_FIRST;
        end
        default: begin
          // unused slot code restarts a packet like the first slot
          first_byte <= rx_byte;
          byte_index <= SLOT_SECOND;
        end
      endcase
    end
  end

  assign frame.last_slot   = (byte_index == SLOT_THIRD);
  assign frame.first_byte  = first_byte;
  assign frame.second_byte = second_byte;

endmodule

@@ sv/pmct_track.sv @@
`timescale 1ns / 1ps

module pmct_track #(
  parameter int SCALE_SHIFT = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        update,
  input  pmct_pkg::frame_t            frame,
  input  logic [pmct_pkg::BYTE_W-1:0] third_byte,
  input  pmct_pkg::cfg_t              cfg,
  output pmct_pkg::result_t           result
);
  import pmct_pkg::*;

  localparam int SUM_W = POS_W + 2;

  logic [POS_W-1:0]        fine_x;
  logic [POS_W-1:0]        fine_y;
  logic [POS_W-1:0]        fine_x_next;
  logic [POS_W-1:0]        fine_y_next;
  logic signed [SUM_W-1:0] dx;
  logic signed [SUM_W-1:0] dy;
  logic signed [SUM_W-1:0] sum_x;
  logic signed [SUM_W-1:0] sum_y;
  logic [POS_W-1:0]        row_full;
  logic [POS_W-1:0]        col_full;

  function automatic logic [POS_W-1:0] clamp_pos(input logic signed [SUM_W-1:0] v,
                                                  input logic [POS_W-1:0] lim);
    logic signed [SUM_W-1:0] lim_s;
    logic signed [SUM_W-1:0] r;
    lim_s = $signed({2'b00, lim});
    r = (v > lim_s) ? lim_s : v;
    if (r < 0) r = '0;
    return r[POS_W-1:0];
  endfunction

  always_comb begin
    dx = frame.first_byte[X_OVF_BIT] ? '0
         : SUM_W'($signed(frame.second_byte));
    dy = frame.first_byte[Y_OVF_BIT] ? '0
         : SUM_W'($signed(third_byte));
    sum_x = $signed({2'b00, fine_x}) + dx;
    sum_y = $signed({2'b00, fine_y}) - dy;
    fine_x_next = clamp_pos(sum_x, cfg.x_limit);
    fine_y_next = clamp_pos(sum_y, cfg.y_limit);
    col_full = fine_x_next >> SCALE_SHIFT;
    row_full = fine_y_next >> SCALE_SHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fine_x <= '0;
      fine_y <= '0;
    end else if (update) begin
      fine_x <= fine_x_next;
      fine_y <= fine_y_next;
    end
  end

  // dock test uses the full shifted row, before trimming to the port width
  always_comb begin
    result.cursor_x   = col_full[CUR_W-1:0];
    result.cursor_y   = row_full[CUR_W-1:0];
    result.click      = frame.first_byte[LEFT_BIT];
    result.target_app = '0;
    if (frame.first_byte[LEFT_BIT] && (row_full <= {{(POS_W-ROW_W){1'b0}}, cfg.dock_row}))
      result.target_app = cfg.focus_app;
  end

endmodule

@@ sv/pmct_cfg_regs.sv @@
`timescale 1ns / 1ps

module pmct_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [pmct_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [pmct_pkg::CFG_W-1:0]  cfg_data,
  output pmct_pkg::cfg_t              cfg
);
  import pmct_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_limit   <= X_LIMIT_RST;
      cfg.y_limit   <= Y_LIMIT_RST;
      cfg.dock_row  <= DOCK_ROW_RST;
      cfg.focus_app <= FOCUS_APP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_X_LIMIT:   cfg.x_limit   <= cfg_data;
        REG_Y_LIMIT:   cfg.y_limit   <= cfg_data;
        REG_DOCK_ROW:  cfg.dock_row  <= cfg_data[ROW_W-1:0];
        REG_FOCUS_APP: cfg.focus_app <= cfg_data[APP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/ps2_mouse_cursor_tracker.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Contents
// s_*      | in        | one mouse byte a transfer, in packet order
// m_*      | out       | cursor and click, one transfer per three-byte packet
// cfg_*    | in        | register writes: x_limit, y_limit, dock_row, focus_app
//
// One byte is taken every cycle unless a waiting result stalls it; the result of a packet
// is registered and shows on m_* the cycle after its third byte. The position add and
// clamp sit between the framer registers and the output register.
// rst is synchronous: packet framing restarts, position goes to zero, registers
// take their defaults. A waiting result stalls only the third byte of the next
// packet; first and second bytes are still taken.

module ps2_mouse_cursor_tracker #(
  parameter int SCALE_SHIFT = 3
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [pmct_pkg::IN_DW-1:0]  s_tdata,   // [7:0] rx_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [pmct_pkg::OUT_DW-1:0] m_tdata,   // [8:0] cursor_x, [17:9] cursor_y,
                                                 // [18] click, [21:19] target_app
  input  logic                        cfg_we,
  input  logic [pmct_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [pmct_pkg::CFG_W-1:0]  cfg_data
);
  import pmct_pkg::*;

  cfg_t    cfg;
  frame_t  frame;
  result_t result;
  result_t out_reg;
  logic    take;
  logic    update;

  assign s_tready = frame.last_slot ? (!m_tvalid || m_tready) : 1'b1;
  assign take     = s_tvalid && s_tready;
  assign update   = take && frame.last_slot;

  pmct_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  pmct_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (s_tdata[BYTE_W-1:0]),
    .frame   (frame)
  );

  pmct_track #(
    .SCALE_SHIFT (SCALE_SHIFT)
  ) u_track (
    .clk        (clk),
    .rst        (rst),
    .update     (update),
    .frame      (frame),
    .third_byte (s_tdata[BYTE_W-1:0]),
    .cfg        (cfg),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (update) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {2'b00, out_reg.target_app, out_reg.click,
                    out_reg.cursor_y, out_reg.cursor_x};

endmodule
